// ===== hw/rtl/hyperloglog_register_update_defines.svh =====
// ----------------------------------------------------------------------------
// HyperLogLog register update: assertion macros
// Shared property shapes for the port checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HYPERLOGLOG_REGISTER_UPDATE_DEFINES_SVH
`define HYPERLOGLOG_REGISTER_UPDATE_DEFINES_SVH

// Same-cycle implication
`define HLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hll_pkg.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update: package
// Request/result types, operation codes and hash constants.
// ----------------------------------------------------------------------------
package hll_pkg;

    // Field widths
    localparam int IDX_W  = 14;
    localparam int VAL_W  = 6;
    localparam int LEN_W  = 13;
    localparam int WORD_W = 64;
    localparam int SEED_W = 32;

    // Defaults for the top-level parameters
    localparam int INDEX_BITS_DEF        = 14;
    localparam int MAX_ELEMENT_BYTES_DEF = 4096;

    // MurmurHash64A constants
    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int                MIX_SHIFT  = 47;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'hadc83b19;

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_MERGE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] data_word;
        logic [LEN_W-1:0]  elem_len;
        logic              last;
        logic [IDX_W-1:0]  reg_index;
        logic [VAL_W-1:0]  reg_value;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [VAL_W-1:0]  out_value;
        logic [VAL_W-1:0]  rank;
        logic              updated;
        logic [WORD_W-1:0] hash_value;
    } t_rsp;

endpackage

// ===== hw/rtl/hyperloglog_register_update.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update
// Dense HyperLogLog register file with a MurmurHash64A front end.
// Add streams element words through the hash, then raises the selected
// register to the rank of the hash; merge raises a register; read returns one.
// ----------------------------------------------------------------------------
//  Channel   | Signals                      | Handshake
//  ----------+------------------------------+------------------------------------
//  request   | i_req (t_req)                | taken when start && !busy
//  result    | o_rsp (t_rsp)                | o_strobe high for one cycle
//  config    | i_cfg_wdata (hash seed)      | written when i_cfg_we is high
//
//  After reset a clearing pass zeroes the store, busy high. Each 64-bit multiply
//  runs on the shared 32x32 multiplier. An add word past the element end hashes
//  nothing; a tail word runs the hash multiply, a full block the two key
//  multiplies and the hash multiply, and a first word runs the start value
//  multiply before these; a final word adds the final mix, rank search and update.
//  Results cannot be stalled; o_rsp holds until the next result.
// ----------------------------------------------------------------------------
module hyperloglog_register_update #(
    parameter int INDEX_BITS        = hll_pkg::INDEX_BITS_DEF,
    parameter int MAX_ELEMENT_BYTES = hll_pkg::MAX_ELEMENT_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hll_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [hll_pkg::SEED_W-1:0]    i_cfg_wdata,
    output logic                          o_strobe,
    output hll_pkg::t_rsp                 o_rsp
);

    localparam int DEPTH     = 1 << INDEX_BITS;
    localparam int TAIL_BITS = 64 - INDEX_BITS;
    localparam int REST_W    = TAIL_BITS + 1;
    localparam int LEN_W     = hll_pkg::LEN_W;
    localparam int VAL_W     = hll_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SEED, S_ABSORB, S_K1, S_K2, S_HMUL,
        S_WEND, S_FIN, S_RANK, S_RD, S_UPD
    } t_state;

    // Trailing-zero count of a nonzero byte
    function automatic logic [2:0] ctz8(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) pos = 3'(i);
        end
        return pos;
    endfunction

    // Registers and next values
    t_state                  r_state, n_state;
    logic [INDEX_BITS-1:0]   r_clr, n_clr;
    logic [31:0]             r_seed;
    logic [63:0]             r_hash_acc, n_hash_acc;
    logic [LEN_W-1:0]        r_bytes_done, n_bytes_done;
    logic [1:0]              r_op, n_op;
    logic [63:0]             r_word, n_word;
    logic [LEN_W-1:0]        r_rem, n_rem;
    logic                    r_last, n_last;
    logic [VAL_W-1:0]        r_val, n_val;
    logic [INDEX_BITS-1:0]   r_addr, n_addr;
    logic [63:0]             r_h, n_h;
    logic [REST_W-1:0]       r_rest, n_rest;
    logic [VAL_W-1:0]        r_rank, n_rank;
    logic                    r_mul_go, n_mul_go;
    logic [63:0]             r_mul_arg, n_mul_arg;
    logic                    r_strobe, n_strobe;
    hll_pkg::t_rsp           r_rsp, n_rsp;
    logic [VAL_W-1:0]        r_rd_data;

    // Register store
    logic [VAL_W-1:0]        mem [DEPTH];
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;

    // Shared multiplier
    logic                    mul_done;
    logic [63:0]             mul_prod;

    // Datapath helpers
    logic [LEN_W-1:0]        len_c;
    logic [LEN_W-1:0]        rem_new;
    logic [LEN_W-1:0]        step_bytes;
    logic [63:0]             tail;
    logic [63:0]             k_mix;
    logic [63:0]             h_fin;
    logic [VAL_W-1:0]        cand;
    logic                    upd;

    hll_mul64 u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_go),
        .i_operand (r_mul_arg),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // Clamp element length and derive remaining bytes
    always_comb begin
        if (17'(i_req.elem_len) > 17'(MAX_ELEMENT_BYTES)) begin
            len_c = LEN_W'(MAX_ELEMENT_BYTES);
        end else begin
            len_c = i_req.elem_len;
        end
        rem_new = (len_c > r_bytes_done) ? len_c - r_bytes_done : '0;
    end

    assign step_bytes = (r_rem >= LEN_W'(8)) ? LEN_W'(8) : r_rem;

    // Tail bytes: keep only the low r_rem bytes
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tail[8*i +: 8] = (LEN_W'(i) < r_rem) ? r_word[8*i +: 8] : 8'h00;
        end
    end

    assign k_mix = mul_prod ^ (mul_prod >> hll_pkg::MIX_SHIFT);
    assign h_fin = r_h ^ (r_h >> hll_pkg::MIX_SHIFT);

    // Max update candidate
    assign cand = (r_op == hll_pkg::OP_ADD) ? r_rank : r_val;
    assign upd  = (r_op != hll_pkg::OP_READ) && (r_rd_data < cand);

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_hash_acc   = r_hash_acc;
        n_bytes_done = r_bytes_done;
        n_op         = r_op;
        n_word       = r_word;
        n_rem        = r_rem;
        n_last       = r_last;
        n_val        = r_val;
        n_addr       = r_addr;
        n_h          = r_h;
        n_rest       = r_rest;
        n_rank       = r_rank;
        n_mul_go     = 1'b0;
        n_mul_arg    = r_mul_arg;
        n_strobe     = 1'b0;
        n_rsp        = r_rsp;
        mem_we       = 1'b0;
        mem_waddr    = r_addr;
        mem_wdata    = cand;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_op   = i_req.op;
                    n_word = i_req.data_word;
                    n_last = i_req.last;
                    n_val  = i_req.reg_value;
                    n_addr = INDEX_BITS'(i_req.reg_index);
                    case (i_req.op)
                        hll_pkg::OP_ADD: begin
                            n_rem = rem_new;
                            if (r_bytes_done == '0) begin
                                n_mul_go  = 1'b1;
                                n_mul_arg = 64'(len_c);
                                n_state   = S_SEED;
                            end else begin
                                n_h     = r_hash_acc;
                                n_state = S_ABSORB;
                            end
                        end
                        hll_pkg::OP_MERGE, hll_pkg::OP_READ: begin
                            n_state = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEED: begin
                if (mul_done) begin
                    n_h     = {32'h0, r_seed} ^ mul_prod;
                    n_state = S_ABSORB;
                end
            end
            S_ABSORB: begin
                n_bytes_done = r_bytes_done + step_bytes;
                if (r_rem >= LEN_W'(8)) begin
                    n_mul_go  = 1'b1;
                    n_mul_arg = r_word;
                    n_state   = S_K1;
                end else if (r_rem != '0) begin
                    n_h       = r_h ^ tail;
                    n_mul_go  = 1'b1;
                    n_mul_arg = r_h ^ tail;
                    n_state   = S_HMUL;
                end else begin
                    n_state = S_WEND;
                end
            end
            S_K1: begin
                if (mul_done) begin
                    n_mul_go  = 1'b1;
                    n_mul_arg = k_mix;
                    n_state   = S_K2;
                end
            end
            S_K2: begin
                if (mul_done) begin
                    n_h       = r_h ^ mul_prod;
                    n_mul_go  = 1'b1;
                    n_mul_arg = r_h ^ mul_prod;
                    n_state   = S_HMUL;
                end
            end
            S_HMUL: begin
                if (mul_done) begin
                    n_h     = mul_prod;
                    n_state = S_WEND;
                end
            end
            S_WEND: begin
                if (!r_last) begin
                    n_hash_acc = r_h;
                    n_state    = S_IDLE;
                end else begin
                    n_hash_acc   = '0;
                    n_bytes_done = '0;
                    n_mul_go     = 1'b1;
                    n_mul_arg    = h_fin;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                // final mix done: pick register, set sentinel above the tail
                if (mul_done) begin
                    n_h     = k_mix;
                    n_addr  = k_mix[INDEX_BITS-1:0];
                    n_rest  = {1'b1, k_mix[63:INDEX_BITS]};
                    n_rank  = VAL_W'(1);
                    n_state = S_RANK;
                end
            end
            S_RANK: begin
                // one byte of the trailing-zero search per cycle
                if (r_rest[7:0] == 8'h00) begin
                    n_rest = r_rest >> 8;
                    n_rank = r_rank + VAL_W'(8);
                end else begin
                    n_rank  = r_rank + VAL_W'(ctz8(r_rest[7:0]));
                    n_state = S_UPD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                mem_we               = upd;
                n_strobe             = 1'b1;
                n_rsp.out_index      = hll_pkg::IDX_W'(r_addr);
                n_rsp.out_value      = upd ? cand : r_rd_data;
                n_rsp.rank           = (r_op == hll_pkg::OP_ADD) ? r_rank : '0;
                n_rsp.updated        = upd;
                n_rsp.hash_value     = (r_op == hll_pkg::OP_ADD) ? r_h : '0;
                n_state              = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_seed       <= hll_pkg::SEED_RESET;
            r_hash_acc   <= '0;
            r_bytes_done <= '0;
            r_mul_go     <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_hash_acc   <= n_hash_acc;
            r_bytes_done <= n_bytes_done;
            r_op         <= n_op;
            r_word       <= n_word;
            r_rem        <= n_rem;
            r_last       <= n_last;
            r_val        <= n_val;
            r_addr       <= n_addr;
            r_h          <= n_h;
            r_rest       <= n_rest;
            r_rank       <= n_rank;
            r_mul_go     <= n_mul_go;
            r_mul_arg    <= n_mul_arg;
            r_strobe     <= n_strobe;
            r_rsp        <= n_rsp;
            if (i_cfg_we) r_seed <= i_cfg_wdata;
        end
    end

    // Register store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[r_addr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== hw/rtl/hll_mul64.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update: 64-bit multiply by the mix constant
// Low 64 bits of operand * MIX_MUL, built from three 32x32 partial
// products on one multiplier, one per cycle.
// ----------------------------------------------------------------------------
module hll_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_operand,
    output logic        o_done,
    output logic [63:0] o_product
);

    localparam logic [31:0] M_LO = hll_pkg::MIX_MUL[31:0];
    localparam logic [31:0] M_HI = hll_pkg::MIX_MUL[63:32];

    logic        r_run;
    logic [1:0]  r_step;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_pp;
    logic [63:0] r_acc;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_out;

    // Operand select: lo*lo, lo*hi, hi*lo
    assign mul_a   = (r_step == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mul_b   = (r_step == 2'd1) ? M_HI : M_LO;
    assign mul_out = 64'(mul_a) * 64'(mul_b);

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= 2'd0;
            end else if (r_run) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: product register, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_operand;
        end else if (r_run) begin
            r_pp <= mul_out;
            case (r_step)
                2'd0: ;
                2'd1: r_acc <= r_pp;
                default: r_acc <= r_acc + {r_pp[31:0], 32'h0};
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== hw/rtl/hll_checker.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update: port checker
// Watches the top-level ports for request/result ordering and result
// consistency; bound to the top level below.
// ----------------------------------------------------------------------------
`include "hyperloglog_register_update_defines.svh"

module hll_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input hll_pkg::t_req i_req,
    input logic          o_strobe,
    input hll_pkg::t_rsp o_rsp
);

    logic req_valid_op;
    logic raise_ok;

    assign req_valid_op = (i_req.op == hll_pkg::OP_ADD) || (i_req.op == hll_pkg::OP_MERGE)
                          || (i_req.op == hll_pkg::OP_READ);
    assign raise_ok     = (o_rsp.out_value != '0) && (o_rsp.out_value >= o_rsp.rank);

    // a real request keeps the block busy on the next cycle
    `HLL_ASSERT_NEXT(a_req_busy, start && !busy && req_valid_op, busy, "request not taken up")
    // results only follow a busy cycle
    `HLL_ASSERT_NOW(a_strobe_after_busy, o_strobe, $past(busy), "result without work")
    // merge and read carry no hash
    `HLL_ASSERT_NOW(a_no_hash, o_strobe && (o_rsp.rank == '0), o_rsp.hash_value == '0, "stray hash")
    // a raised register holds at least the rank
    `HLL_ASSERT_NOW(a_raise, o_strobe && o_rsp.updated, raise_ok, "bad raise")

endmodule

bind hyperloglog_register_update hll_checker u_hll_checker (.*);

// ===== tb/hyperloglog_register_update_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HyperLogLog register update: result checker
// Watches the request, result and seed channels of the block. Every accepted
// request runs through a local copy of the register store and the streaming
// MurmurHash64A state; the results it implies wait in order and each strobed
// result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module hyperloglog_register_update_checker
    import hll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [SEED_W-1:0] i_cfg_wdata,
    input  logic              i_strobe,
    input  t_rsp              i_rsp,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_hashed,
    output int                o_raised
);

    localparam int INDEX_BITS = INDEX_BITS_DEF;
    localparam int NUM_REGS   = 1 << INDEX_BITS;
    localparam int RANK_SPAN  = WORD_W - INDEX_BITS;
    localparam int MAX_BYTES  = MAX_ELEMENT_BYTES_DEF;
    localparam int SHOW_LIMIT = 10;

    // Local copy of the block state
    logic [VAL_W-1:0]  hll_regs [NUM_REGS];
    logic [WORD_W-1:0] run_hash;
    int                run_bytes;
    logic [SEED_W-1:0] seed;

    // Results owed by the block, oldest first
    t_rsp owed_rsp [$];

    int errors  = 0;
    int checked = 0;
    int hashed  = 0;
    int raised  = 0;

    task automatic clear_state();
        for (int i = 0; i < NUM_REGS; i++) hll_regs[i] = '0;
        run_hash  = '0;
        run_bytes = 0;
        seed      = SEED_RESET;
        owed_rsp.delete();
    endtask

    // Max-update of one register, reports whether it went up
    function automatic logic raise_reg(input logic [IDX_W-1:0] idx,
                                       input logic [VAL_W-1:0] val);
        if (hll_regs[idx] < val) begin
            hll_regs[idx] = val;
            raised++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One plus trailing zeros above the index bits, sentinel caps the count
    function automatic logic [VAL_W-1:0] run_length(input logic [WORD_W-1:0] hv);
        logic [WORD_W-1:0] rest;
        logic [VAL_W-1:0]  n;
        rest = (hv >> INDEX_BITS) | (64'd1 << RANK_SPAN);
        n    = VAL_W'(1);
        while (!rest[0]) begin
            rest = rest >> 1;
            n++;
        end
        return n;
    endfunction

    // Apply one request, queue the result it implies
    task automatic absorb_request(input t_req r);
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] hv;
        logic [WORD_W-1:0] len64;
        int                len;
        int                remaining;
        t_rsp              res;
        res = '0;
        case (r.op)
            OP_ADD: begin
                len = int'(r.elem_len);
                if (len > MAX_BYTES) len = MAX_BYTES;
                len64 = 64'(len);
                // start value only on the first word of an element
                if (run_bytes == 0) h = {32'd0, seed} ^ (len64 * MIX_MUL);
                else h = run_hash;
                remaining = (len > run_bytes) ? len - run_bytes : 0;
                if (remaining >= 8) begin
                    k = r.data_word * MIX_MUL;
                    k = k ^ (k >> MIX_SHIFT);
                    k = k * MIX_MUL;
                    h = (h ^ k) * MIX_MUL;
                    run_bytes += 8;
                end else if (remaining > 0) begin
                    // tail: only the remaining low bytes count
                    h = (h ^ (r.data_word & ((64'd1 << (8 * remaining)) - 64'd1))) * MIX_MUL;
                    run_bytes += remaining;
                end
                if (!r.last) begin
                    run_hash = h;
                end else begin
                    hv = h ^ (h >> MIX_SHIFT);
                    hv = hv * MIX_MUL;
                    hv = hv ^ (hv >> MIX_SHIFT);
                    res.out_index  = hv[IDX_W-1:0];
                    res.rank       = run_length(hv);
                    res.updated    = raise_reg(res.out_index, res.rank);
                    res.out_value  = hll_regs[res.out_index];
                    res.hash_value = hv;
                    run_hash  = '0;
                    run_bytes = 0;
                    hashed++;
                    owed_rsp.push_back(res);
                end
            end
            OP_MERGE: begin
                res.out_index = r.reg_index;
                res.updated   = raise_reg(r.reg_index, r.reg_value);
                res.out_value = hll_regs[r.reg_index];
                owed_rsp.push_back(res);
            end
            OP_READ: begin
                res.out_index = r.reg_index;
                res.out_value = hll_regs[r.reg_index];
                owed_rsp.push_back(res);
            end
            default: ;  // unused code: no effect, no result
        endcase
    endtask

    task automatic compare_result(input t_rsp got);
        t_rsp want;
        if (owed_rsp.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: result with nothing owed: idx %0d val %0d rank %0d upd %0d hash %h",
                         $time, got.out_index, got.out_value, got.rank, got.updated,
                         got.hash_value);
            return;
        end
        want = owed_rsp.pop_front();
        checked++;
        if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
            got.rank !== want.rank || got.updated !== want.updated ||
            got.hash_value !== want.hash_value) begin
            errors++;
            if (errors <= SHOW_LIMIT) begin
                $display("%0t: result mismatch", $time);
                $display("    expected idx %0d val %0d rank %0d upd %0d hash %h",
                         want.out_index, want.out_value, want.rank, want.updated,
                         want.hash_value);
                $display("    actual   idx %0d val %0d rank %0d upd %0d hash %h",
                         got.out_index, got.out_value, got.rank, got.updated,
                         got.hash_value);
            end
        end
    endtask

    // Results are checked before the request of the same edge is absorbed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_we) seed = i_cfg_wdata;
            if (i_strobe) compare_result(i_rsp);
            if (i_start && !i_busy) absorb_request(i_req);
        end
        o_errors  <= errors;
        o_pending <= owed_rsp.size();
        o_checked <= checked;
        o_hashed  <= hashed;
        o_raised  <= raised;
    end

endmodule

// ===== tb/hyperloglog_register_update_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HyperLogLog register update: testbench top
// Drives element words, merges and reads into the block under four hash
// seeds and three sender idle rates; the checker beside the block predicts
// and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module hyperloglog_register_update_test;
    import hll_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS  = 270;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_GAP      = 30;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int MAX_LEN_FIELD = (1 << LEN_W) - 1;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    t_req              req       = '0;
    logic              cfg_we    = 1'b0;
    logic [SEED_W-1:0] cfg_wdata = '0;
    logic              strobe;
    t_rsp              rsp;

    int errors;
    int pending;
    int checked;
    int hashed;
    int raised;
    int sent    = 0;
    int gap_pct = 0;

    // Recently returned register numbers, reused to hit live registers
    logic [IDX_W-1:0] seen_idx [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    hyperloglog_register_update u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (req),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .o_strobe   (strobe),
        .o_rsp      (rsp)
    );

    hyperloglog_register_update_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (req),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_strobe   (strobe),
        .i_rsp      (rsp),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_hashed   (hashed),
        .o_raised   (raised)
    );

    always @(posedge i_clk) begin
        if (strobe) begin
            seen_idx.push_back(rsp.out_index);
            if (seen_idx.size() > 32) void'(seen_idx.pop_front());
        end
    end

    // Request builders: fields the operation ignores stay random
    function automatic t_req rand_req(input logic [1:0] op);
        t_req r;
        r.op        = op;
        r.data_word = {$urandom, $urandom};
        r.elem_len  = LEN_W'($urandom);
        r.last      = 1'($urandom);
        r.reg_index = IDX_W'($urandom);
        r.reg_value = VAL_W'($urandom);
        return r;
    endfunction

    function automatic t_req add_word(input logic [WORD_W-1:0] data, input int len,
                                      input logic last);
        t_req r;
        r           = rand_req(OP_ADD);
        r.data_word = data;
        r.elem_len  = LEN_W'(len);
        r.last      = last;
        return r;
    endfunction

    function automatic t_req reg_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                     input logic [VAL_W-1:0] val);
        t_req r;
        r           = rand_req(op);
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int               sel;
        logic [IDX_W-1:0] v;
        sel = $urandom_range(9);
        if (sel < 6 && seen_idx.size() > 0) return seen_idx[$urandom_range(seen_idx.size() - 1)];
        if (sel == 6) return '0;
        if (sel == 7) return '1;
        v = IDX_W'($urandom);
        return v;
    endfunction

    // Merge or read, merge values often small to land near add ranks
    function automatic t_req rand_reg_op();
        t_req r;
        r = reg_req($urandom_range(1) ? OP_MERGE : OP_READ, pick_index(), VAL_W'($urandom));
        if ($urandom_range(1)) r.reg_value = VAL_W'($urandom_range(0, 12));
        return r;
    endfunction

    function automatic int word_count(input int len);
        return (len == 0) ? 1 : (len + 7) / 8;
    endfunction

    // Hold the request until taken, then maybe idle before the next one
    task automatic send_req(input t_req r);
        int gap;
        req   <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.op != OP_UNUSED) sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            req   <= rand_req(2'($urandom));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Element words with last on the final one, optional register traffic between
    task automatic send_element(input int len, input int words, input logic chatter);
        for (int w = 0; w < words; w++) begin
            send_req(add_word({$urandom, $urandom}, len, w == words - 1));
            if (chatter && w < words - 1 && $urandom_range(2) == 0) send_req(rand_reg_op());
        end
    endtask

    // Wait until every owed result is in, then let the block settle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        // register extremes, merge with and without a raise
        send_req(reg_req(OP_READ, '0, '0));
        send_req(reg_req(OP_MERGE, '0, '1));
        send_req(reg_req(OP_MERGE, '0, 6'd5));
        send_req(reg_req(OP_MERGE, '1, '0));
        send_req(reg_req(OP_MERGE, '1, 6'd1));
        send_req(reg_req(OP_READ, '1, '0));
        // empty element, one full block, tail only
        send_req(add_word('0, 0, 1'b1));
        send_req(add_word('1, 8, 1'b1));
        send_req(add_word('0, 3, 1'b1));
        // full block plus tail
        send_element(13, 2, 1'b0);
        // length above and at the bound, cut short by last
        send_element(MAX_LEN_FIELD, 2, 1'b0);
        send_element(MAX_ELEMENT_BYTES_DEF, 1, 1'b0);
        // word past the end of the element is ignored
        send_element(4, 2, 1'b0);
        // length drops mid element, leaving a 4-byte tail
        send_req(add_word({$urandom, $urandom}, 16, 1'b0));
        send_req(add_word({$urandom, $urandom}, 12, 1'b1));
        // register traffic between words of one element
        send_req(add_word({$urandom, $urandom}, 16, 1'b0));
        send_req(reg_req(OP_MERGE, pick_index(), 6'd7));
        send_req(reg_req(OP_READ, pick_index(), '0));
        send_req(add_word({$urandom, $urandom}, 16, 1'b1));
        send_req(rand_req(OP_UNUSED));
        send_req(reg_req(OP_READ, pick_index(), '0));
    endtask

    task automatic run_sequence();
        int sel;
        int len;
        int words;
        sel = $urandom_range(99);
        if (sel < 55) begin
            // well-formed element
            len = ($urandom_range(9) == 0) ? $urandom_range(33, 200) : $urandom_range(0, 32);
            send_element(len, word_count(len), $urandom_range(3) == 0);
        end else if (sel < 85) begin
            send_req(rand_reg_op());
        end else begin
            case ($urandom_range(5))
                0: begin  // last before the length is used up
                    len = $urandom_range(9, 64);
                    send_element(len, $urandom_range(1, word_count(len) - 1), 1'b0);
                end
                1: begin  // words beyond the element length
                    len = $urandom_range(0, 24);
                    send_element(len, word_count(len) + $urandom_range(1, 2), 1'b0);
                end
                2: begin  // length field changes from word to word
                    words = $urandom_range(2, 4);
                    for (int w = 0; w < words; w++)
                        send_req(add_word({$urandom, $urandom}, $urandom_range(0, 40),
                                          w == words - 1));
                end
                3: send_req(rand_req(OP_UNUSED));
                4: send_req(add_word({$urandom, $urandom}, $urandom_range(0, 40), 1'b0));
                default: begin  // length at or above the bound
                    len = ($urandom_range(1) == 0) ? MAX_ELEMENT_BYTES_DEF
                        : $urandom_range(MAX_ELEMENT_BYTES_DEF + 1, MAX_LEN_FIELD);
                    send_element(len, $urandom_range(1, 3), 1'b0);
                end
            endcase
        end
    endtask

    // Random traffic, closed with a final word so no element stays open
    task automatic run_random(input int count);
        int target;
        target = sent + count;
        while (sent < target) run_sequence();
        send_req(add_word({$urandom, $urandom}, $urandom_range(0, 16), 1'b1));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 18;
        run_directed();
        drain();
        write_seed('0);
        run_random(PHASE_ITEMS);

        drain();
        write_seed('1);
        gap_pct = 48;
        run_random(PHASE_ITEMS);

        drain();
        write_seed($urandom);
        gap_pct = 0;
        run_random(PHASE_ITEMS);

        drain();
        $display("covered %0d requests under four hash seeds and three sender idle rates",
                 sent);
        $display("checked %0d results: %0d hashed elements, %0d register raises",
                 checked, hashed, raised);
        if (pending != 0) $display("%0d results never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("hyperloglog_register_update_test: clean");
        end else begin
            $display("hyperloglog_register_update_test: errors");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: block stopped making progress");
        $display("hyperloglog_register_update_test: errors");
        $finish;
    end

endmodule

// ===== hyperloglog_register_update.f =====
+incdir+hw/rtl
hw/rtl/hll_pkg.sv
hw/rtl/hll_mul64.sv
hw/rtl/hyperloglog_register_update.sv
hw/rtl/hll_checker.sv
tb/hyperloglog_register_update_checker.sv
tb/hyperloglog_register_update_test.sv
